// ===== rtl/lane_follow_speed_governor_top_macros.svh =====
// Assertion macros for the lane-follow speed governor checker.
`ifndef LANE_FOLLOW_SPEED_GOVERNOR_TOP_MACROS_SVH
`define LANE_FOLLOW_SPEED_GOVERNOR_TOP_MACROS_SVH

// Property sampled on the rising clock edge, muted while reset is low.
`define LFSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal holds in the cycle after a condition.
`define LFSG_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/lfsg_pkg.sv =====
// Package for the lane-follow speed governor: beat types, register indexes, constants.
package lfsg_pkg;

  typedef struct packed {
    logic               track_valid;
    logic signed [15:0] track_offset;
    logic signed [15:0] track_vx;
    logic signed [15:0] track_vy;
    logic [23:0]        track_pos;
    logic [23:0]        own_pos;
    logic [15:0]        own_speed;
    logic [5:0]         path_len;
    logic               last_track;
  } in_item_t;

  typedef struct packed {
    logic        close_seen;
    logic [15:0] ref_speed;
    logic        frame_done;
  } out_item_t;

  // register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_LANE_INDEX   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOLLOW_GAP   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOP_SPEED    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_STEP   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_MARGIN = 3'd4;

  // register reset values
  localparam logic [1:0]  RST_LANE_INDEX   = 2'd1;
  localparam logic [15:0] RST_FOLLOW_GAP   = 16'd7680;
  localparam logic [15:0] RST_TOP_SPEED    = 16'd50944;
  localparam logic [11:0] RST_SPEED_STEP   = 12'd229;
  localparam logic [11:0] RST_SPEED_MARGIN = 12'd115;
  localparam logic [15:0] RST_REF_SPEED    = 16'd50688;

  // shared multiplier operands
  localparam int unsigned MulW = 24;
  // floor(x/50) = (x*RECIP_50) >> 28 for x < 2^22
  localparam logic [MulW-1:0] RECIP_50   = 24'd5368710;
  // floor(z/1125) = (z*RECIP_1125) >> 33 for z < 2^23
  localparam logic [MulW-1:0] RECIP_1125 = 24'd7635498;
  // 2.23694*4 in Q14: 1/256 m/s to 1/1024 mph
  localparam logic [MulW-1:0] MPH_K      = 24'd146600;
  localparam logic [21:0]     ROUND_50   = 22'd25;
  localparam logic [33:0]     ROUND_MPH  = 34'd8192;
  localparam logic [31:0]     ROUND_DEC  = 32'd288000;
  localparam logic [15:0]     GAP_ZERO   = 16'd7680;   // 30 m
  localparam logic [31:0]     SQRT_BIT0  = 32'h4000_0000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQX,
    OP_SQY,
    OP_SUM,
    OP_SQRT,
    OP_ADV,
    OP_DIV50,
    OP_GAP,
    OP_MPH,
    OP_CMP,
    OP_DSQ,
    OP_DDIV,
    OP_DEC,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_lane;     // vehicle beat inside the watched lane
    logic hit;         // ahead within the gap (valid during OP_GAP)
    logic slower;      // lead slower by more than the margin (valid during OP_CMP)
    logic sqrt_last;   // final root iteration pair
  } sts_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] res;
  } sqrt_st_t;

  // one digit of the bitwise integer square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [31:0] b);
    sqrt_st_t    r;
    logic [32:0] t;
    t = {1'b0, s.res} + {1'b0, b};
    if ({1'b0, s.rem} >= t) begin
      r.rem = s.rem - t[31:0];
      r.res = (s.res >> 1) + b;
    end else begin
      r.rem = s.rem;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/lane_follow_speed_governor_top.sv =====
// One beat at a time: a new beat is accepted only after the last one has left the
//   frame-end step. The root loop and the single shared 24x24 multiplier that every
//   product goes through set how long each beat takes.
// Reset (rst_ni low, asynchronous): registers back to their defaults, reference speed 50688,
//   close flag clear, no result pending. No clearing pass.
module lane_follow_speed_governor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input beats: one tracked vehicle (or an empty frame marker)
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lfsg_pkg::in_item_t           in_data_i,
  // result beats: one per input beat
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lfsg_pkg::out_item_t          out_data_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfsg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);
  import lfsg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Register writes are taken in any cycle; unknown indexes fall through the
  // decode in the datapath and change nothing.
  assign cfg_ready_o = 1'b1;

  // Sequencer. Per vehicle beat inside the lane:
  //   square vx, square vy, sum, the root loop (two digits per pass),
  //   path_len*v, divide by 50 (reciprocal multiply), gap test,
  //   mph conversion, margin test, gap error squared, divide by 576000,
  //   saturating decrease, then the frame-end rule and result load.
  // Beats that fail the lane, gap or margin test jump straight to the
  // frame-end step. The result register is free for the next beat to be
  // accepted while a finished one still waits; the frame-end step stalls only
  // if the previous result has not been taken yet.
  lfsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: configuration, reference speed, sticky flag, working registers.
  lfsg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/lfsg_ctrl.sv =====
// Sequencer for the lane-follow speed governor: steps the datapath through one beat.
module lfsg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  lfsg_pkg::sts_t sts_i,
  output lfsg_pkg::cmd_t cmd_o
);
  import lfsg_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQX   = 4'd1;
  localparam logic [3:0] ST_SQY   = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_ADV   = 4'd5;
  localparam logic [3:0] ST_DIV50 = 4'd6;
  localparam logic [3:0] ST_GAP   = 4'd7;
  localparam logic [3:0] ST_MPH   = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;
  localparam logic [3:0] ST_DSQ   = 4'd10;
  localparam logic [3:0] ST_DDIV  = 4'd11;
  localparam logic [3:0] ST_DEC   = 4'd12;
  localparam logic [3:0] ST_FIN   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       fin_go;

  assign fin_go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_SQX;
        end
      end
      ST_SQX: begin
        if (sts_i.in_lane) begin
          cmd_o.op = OP_SQX;
          state_d  = ST_SQY;
        end else begin
          state_d  = ST_FIN;
        end
      end
      ST_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (sts_i.sqrt_last) state_d = ST_ADV;
      end
      ST_ADV: begin
        cmd_o.op = OP_ADV;
        state_d  = ST_DIV50;
      end
      ST_DIV50: begin
        cmd_o.op = OP_DIV50;
        state_d  = ST_GAP;
      end
      ST_GAP: begin
        cmd_o.op = OP_GAP;
        state_d  = sts_i.hit ? ST_MPH : ST_FIN;
      end
      ST_MPH: begin
        cmd_o.op = OP_MPH;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.op = OP_CMP;
        state_d  = sts_i.slower ? ST_DSQ : ST_FIN;
      end
      ST_DSQ: begin
        cmd_o.op = OP_DSQ;
        state_d  = ST_DDIV;
      end
      ST_DDIV: begin
        cmd_o.op = OP_DDIV;
        state_d  = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.op = OP_DEC;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          cmd_o.op = OP_FIN;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (state_q == ST_FIN && fin_go) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/lfsg_dp.sv =====
// Datapath for the lane-follow speed governor: shared multiplier, root, speed state.
module lfsg_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfsg_pkg::in_item_t             in_data_i,
  input  lfsg_pkg::cmd_t                 cmd_i,
  output lfsg_pkg::sts_t                 sts_o,
  input  logic                           cfg_we_i,
  input  logic [lfsg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  output lfsg_pkg::out_item_t            out_data_o
);
  import lfsg_pkg::*;

  // configuration
  logic [1:0]  lane_q;
  logic [15:0] gap_lim_q, top_q;
  logic [11:0] step_q, margin_q;

  // speed state
  logic [15:0] ref_q, ref_d;
  logic        close_q, close_d;

  // working registers
  in_item_t        item_q;
  logic [2*MulW-1:0] p_q;
  logic [31:0]     acc_q, res_q, bit_q;
  logic [15:0]     gap_q, diff_q;
  out_item_t       out_q;

  // multiplier
  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] prod;

  logic [15:0] ax, ay, v;
  logic signed [16:0] d17, lo17, hi17;
  logic [21:0] adv_x;
  logic [16:0] adv;
  logic [24:0] spos, gap_full;
  logic [33:0] mph_sum;
  logic [20:0] mph_cmp;
  logic [31:0] dec_y;
  logic [12:0] dec;
  logic [16:0] ref_inc;
  sqrt_st_t    sq0, sq1, sq2;

  assign ax = item_q.track_vx[15] ? 16'(-item_q.track_vx) : item_q.track_vx;
  assign ay = item_q.track_vy[15] ? 16'(-item_q.track_vy) : item_q.track_vy;
  assign v  = res_q[15:0];

  assign d17  = 17'(item_q.track_offset);
  assign lo17 = signed'({5'd0, lane_q, 10'd0});
  assign hi17 = lo17 + 17'sd1024;

  assign adv_x   = p_q[21:0] + ROUND_50;
  assign adv     = p_q[44:28];
  assign spos    = {1'b0, item_q.track_pos} + {8'd0, adv};
  assign gap_full = spos - {1'b0, item_q.own_pos};

  assign mph_sum = p_q[33:0] + ROUND_MPH;
  assign mph_cmp = {1'b0, mph_sum[33:14]} + {9'd0, margin_q};

  assign dec_y = p_q[31:0] + ROUND_DEC;
  assign dec   = p_q[45:33];

  assign sq0 = '{rem: acc_q, res: res_q};
  assign sq1 = sqrt_step(sq0, bit_q);
  assign sq2 = sqrt_step(sq1, bit_q >> 2);

  always_comb begin
    mul_a = {8'd0, ax};
    mul_b = {8'd0, ax};
    case (cmd_i.op)
      OP_SQY:   begin mul_a = {8'd0, ay};          mul_b = {8'd0, ay};     end
      OP_ADV:   begin mul_a = {18'd0, item_q.path_len}; mul_b = {8'd0, v}; end
      OP_DIV50: begin mul_a = {2'd0, adv_x};       mul_b = RECIP_50;       end
      OP_MPH:   begin mul_a = {8'd0, v};           mul_b = MPH_K;          end
      OP_DSQ:   begin mul_a = {8'd0, diff_q};      mul_b = {8'd0, diff_q}; end
      OP_DDIV:  begin mul_a = {1'b0, dec_y[31:9]}; mul_b = RECIP_1125;     end
      default:  begin mul_a = {8'd0, ax};          mul_b = {8'd0, ax};     end
    endcase
  end

  assign prod = mul_a * mul_b;

  // status
  assign sts_o.in_lane   = item_q.track_valid && (d17 > lo17) && (d17 < hi17);
  assign sts_o.hit       = (spos > {1'b0, item_q.own_pos}) &&
                           (gap_full < {9'd0, gap_lim_q});
  assign sts_o.slower    = mph_cmp < {5'd0, item_q.own_speed};
  assign sts_o.sqrt_last = bit_q[2];

  // speed state update
  always_comb begin
    ref_d   = ref_q;
    close_d = close_q;
    ref_inc = {1'b0, ref_q} + {5'd0, step_q};
    case (cmd_i.op)
      OP_GAP: if (sts_o.hit) close_d = 1'b1;
      OP_DEC: ref_d = (ref_q <= {3'd0, dec}) ? 16'd0 : ref_q - {3'd0, dec};
      OP_FIN: begin
        if (item_q.last_track) begin
          if (!close_q && ref_q < top_q) ref_d = ref_inc[16] ? 16'hFFFF : ref_inc[15:0];
          close_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q    <= RST_LANE_INDEX;
      gap_lim_q <= RST_FOLLOW_GAP;
      top_q     <= RST_TOP_SPEED;
      step_q    <= RST_SPEED_STEP;
      margin_q  <= RST_SPEED_MARGIN;
      ref_q     <= RST_REF_SPEED;
      close_q   <= 1'b0;
    end else begin
      ref_q   <= ref_d;
      close_q <= close_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LANE_INDEX:   lane_q    <= cfg_data_i[1:0];
          CFG_FOLLOW_GAP:   gap_lim_q <= cfg_data_i;
          CFG_TOP_SPEED:    top_q     <= cfg_data_i;
          CFG_SPEED_STEP:   step_q    <= cfg_data_i[11:0];
          CFG_SPEED_MARGIN: margin_q  <= cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q <= prod;
    case (cmd_i.op)
      OP_LOAD: item_q <= in_data_i;
      OP_SQY:  acc_q  <= p_q[31:0];
      OP_SUM: begin
        acc_q <= acc_q + p_q[31:0];
        res_q <= '0;
        bit_q <= SQRT_BIT0;
      end
      OP_SQRT: begin
        acc_q <= sq2.rem;
        res_q <= sq2.res;
        bit_q <= bit_q >> 4;
      end
      OP_GAP:  gap_q  <= gap_full[15:0];
      OP_CMP:  diff_q <= (gap_q > GAP_ZERO) ? gap_q - GAP_ZERO : GAP_ZERO - gap_q;
      OP_FIN: begin
        out_q.close_seen <= close_q;
        out_q.ref_speed  <= ref_d;
        out_q.frame_done <= item_q.last_track;
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/lfsg_checker.sv =====
// Port checker for the lane-follow speed governor, bound to the top level.
`include "lane_follow_speed_governor_top_macros.svh"

module lfsg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input lfsg_pkg::out_item_t          out_data_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o
);
  import lfsg_pkg::*;

  // a stalled result stays offered
  `LFSG_ASSERT(ap_out_keep, out_valid_o && !out_ready_i |=> out_valid_o, "result beat dropped")
  `LFSG_ASSERT_HOLD(ap_out_hold, out_valid_o && !out_ready_i, out_data_o, "result beat changed")
  // one beat in flight: the block stays busy after an accept
  `LFSG_ASSERT(ap_busy, in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o,
               "input accepted while busy")
  // register writes never stall
  `LFSG_ASSERT(ap_cfg_rdy, cfg_valid_i |-> cfg_ready_o, "configuration write stalled")

endmodule

bind lane_follow_speed_governor_top lfsg_checker u_lfsg_checker (.*);

// ===== test/lane_follow_speed_governor_top_tb.sv =====
// Self-checking testbench for the lane-follow speed governor: directed and random beats.
module lane_follow_speed_governor_top_tb;
  import lfsg_pkg::*;

  // Run ends here whatever happens; far above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // First register index that the block does not decode.
  localparam int unsigned CFG_FIRST_UNUSED = CFG_SPEED_MARGIN + 1;
  localparam int unsigned BLOCK_BEATS = 160;

  // Shadow of the governor: registers, reference speed and the frame's close flag.
  // Every accepted beat yields exactly one expected result beat.
  class speed_ref_tracker;
    int unsigned lane = RST_LANE_INDEX;
    int unsigned gap = RST_FOLLOW_GAP;
    int unsigned top = RST_TOP_SPEED;
    int unsigned step = RST_SPEED_STEP;
    int unsigned margin = RST_SPEED_MARGIN;
    int unsigned ref_spd = RST_REF_SPEED;
    bit close;
    out_item_t expected_speeds[$];
    int unsigned mismatches;

    // bitwise integer square root
    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // vehicle speed, 1/256 m/s
    function longint unsigned ground_speed(longint vx, longint vy);
      return root(vx * vx + vy * vy);
    endfunction

    // 1/256 m/s to 1/1024 mph, rounded
    function longint unsigned lead_mph(longint unsigned v);
      return (v * MPH_K + ROUND_MPH) >> 14;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_LANE_INDEX:   lane = val[1:0];
        CFG_FOLLOW_GAP:   gap = val;
        CFG_TOP_SPEED:    top = val;
        CFG_SPEED_STEP:   step = val[11:0];
        CFG_SPEED_MARGIN: margin = val[11:0];
        default: ;
      endcase
    endfunction

    function void note_track(in_item_t t);
      out_item_t want;
      longint off, lo;
      longint unsigned v, spos, ahead, diff, dec;
      int unsigned s;
      off = t.track_offset;
      lo = lane * 1024;
      if (t.track_valid && off > lo && off < lo + 1024) begin
        v = ground_speed(t.track_vx, t.track_vy);
        // position advanced for path latency, never wrapped
        spos = t.track_pos + (t.path_len * v + ROUND_50) / 50;
        if (spos > t.own_pos && spos - t.own_pos < gap) begin
          ahead = spos - t.own_pos;
          close = 1'b1;
          if (lead_mph(v) + margin < t.own_speed) begin
            diff = (ahead > GAP_ZERO) ? ahead - GAP_ZERO : GAP_ZERO - ahead;
            dec = (diff * diff + ROUND_DEC) / 576000;
            ref_spd = (dec >= ref_spd) ? 0 : ref_spd - int'(dec);
          end
        end
      end
      want.close_seen = close;
      if (t.last_track) begin
        if (!close && ref_spd < top) begin
          s = ref_spd + step;
          ref_spd = (s > 16'hFFFF) ? 16'hFFFF : s;
        end
        close = 1'b0;
      end
      want.ref_speed = ref_spd[15:0];
      want.frame_done = t.last_track;
      expected_speeds = {expected_speeds, want};
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_speeds.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_speeds.pop_front();
      if (got.close_seen !== want.close_seen) flag("close_seen", want.close_seen, got.close_seen);
      if (got.ref_speed !== want.ref_speed) flag("ref_speed", want.ref_speed, got.ref_speed);
      if (got.frame_done !== want.frame_done) flag("frame_done", want.frame_done, got.frame_done);
    endfunction

    function int unsigned outstanding();
      return expected_speeds.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  speed_ref_tracker tracker = new();

  // Idling: percentage of cycles the sender sits idle / the receiver stalls.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  // Long receiver hold-off, in cycles, counted down by the receiver process.
  int unsigned rx_hold = 0;
  int unsigned cycle_count = 0;

  lane_follow_speed_governor_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check on the accepting edge, then pick next cycle's ready.
  // Values read just after the edge are the pre-edge ones, so no race with the RTL.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) tracker.check_result(out_data_o);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // One input beat; valid may drop only after acceptance, one assignment per edge.
  task automatic send_item(in_item_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_track(t);
  endtask

  // Sender stops and waits for every outstanding result beat.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Full register set, plus a write to an undecoded index that must be dropped.
  task automatic apply_setting(int unsigned lane, int unsigned gap, int unsigned top,
                               int unsigned step, int unsigned margin);
    write_reg(CFG_LANE_INDEX, 16'(lane));
    write_reg(CFG_FOLLOW_GAP, 16'(gap));
    write_reg(CFG_TOP_SPEED, 16'(top));
    write_reg(CFG_SPEED_STEP, 16'(step));
    write_reg(CFG_SPEED_MARGIN, 16'(margin));
    write_reg(CfgIdxW'($urandom_range(2**CfgIdxW - 1, CFG_FIRST_UNUSED)), 16'($urandom));
  endtask

  function automatic in_item_t marker(bit last);
    in_item_t t;
    t = '0;
    t.last_track = last;
    return t;
  endfunction

  // Vehicle inside the watched lane whose advanced position lands `ahead`
  // (1/256 m) in front of the own car.
  function automatic in_item_t aimed(int vx, int vy, int plen, int unsigned ahead,
                                     int unsigned ospd, bit last);
    in_item_t t;
    longint unsigned adv;
    int unsigned opos;
    opos = $urandom_range(24'h7FFFFF, 24'h100000);
    adv = (plen * tracker.ground_speed(vx, vy) + ROUND_50) / 50;
    t.track_valid = 1'b1;
    t.track_offset = 16'(tracker.lane * 1024 + $urandom_range(1023, 1));
    t.track_vx = 16'(vx);
    t.track_vy = 16'(vy);
    t.track_pos = 24'(opos + ahead - adv);
    t.own_pos = 24'(opos);
    t.own_speed = 16'(ospd);
    t.path_len = 6'(plen);
    t.last_track = last;
    return t;
  endfunction

  // Mostly well-formed vehicles near the gap and speed thresholds; some
  // beats with no valid vehicle and some beats with every bit random.
  function automatic in_item_t random_track();
    in_item_t t;
    logic [127:0] raw;
    int vx, vy, plen;
    int unsigned ahead, pick, gap;
    longint spd;
    raw = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 20) begin
      t = raw[$bits(in_item_t)-1:0];
      if (pick < 10) t.track_valid = 1'b0;
      return t;
    end
    gap = tracker.gap;
    vx = $urandom_range(8000);
    if ($urandom_range(1)) vx = -vx;
    vy = int'($urandom_range(600)) - 300;
    plen = $urandom_range(63);
    case ($urandom_range(9))
      0: ahead = 0;
      1: ahead = gap;
      2: ahead = (gap == 0) ? 0 : gap - 1;
      default: ahead = $urandom_range(gap + gap / 8 + 64);
    endcase
    if ($urandom_range(1)) begin
      // own speed straddling the lead's speed plus the margin
      spd = longint'(tracker.lead_mph(tracker.ground_speed(vx, vy)))
            + longint'(tracker.margin) + longint'($urandom_range(400)) - 200;
      if (spd < 0) spd = 0;
      if (spd > 65535) spd = 65535;
    end else begin
      spd = $urandom_range(65535);
    end
    return aimed(vx, vy, plen, ahead, int'(spd), $urandom_range(7) == 0);
  endfunction

  initial begin
    in_item_t t;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values.
    tx_idle_pct = 16;
    rx_stall_pct = 16;
    send_item(marker(1'b0));                        // empty marker mid-frame
    send_item(marker(1'b1));                        // empty frame end: speeds up
    send_item(aimed(2560, 0, 10, 3000, 65535, 1'b0));  // close and slower: brakes
    send_item(aimed(2560, 0, 10, 7679, 0, 1'b1));   // own speed below the margin
    t = aimed(2560, 0, 10, 2000, 65535, 1'b0);
    t.track_offset = 16'(tracker.lane * 1024);      // on the lower lane edge: ignored
    send_item(t);
    t.track_offset = 16'(tracker.lane * 1024 + 1024);  // on the upper edge: ignored
    send_item(t);
    t.track_offset = 16'sh8000;
    send_item(t);
    send_item(aimed(-32768, -32768, 63, 6000, 65535, 1'b0));  // fastest vehicle
    send_item(aimed(2560, 0, 10, 0, 65535, 1'b0));  // level with the car: not ahead
    send_item(aimed(2560, 0, 10, 7680, 65535, 1'b1));  // exactly at the gap: clear

    // Speed ceiling: big steps up to full scale.
    drain();
    apply_setting(2, RST_FOLLOW_GAP, 16'hFFFF, 12'hFFF, RST_SPEED_MARGIN);
    repeat (4) send_item(marker(1'b1));

    // Advanced position past the end of the road, then braking to zero.
    drain();
    apply_setting(0, 16'hFFFF, RST_TOP_SPEED, RST_SPEED_STEP, 0);
    t = aimed(32767, 0, 63, 0, 65535, 1'b0);
    t.track_pos = 24'hFFFFFF;
    t.own_pos = 24'hFFFFF0;
    send_item(t);
    for (int i = 0; i < 12; i++) send_item(aimed(2560, 0, 10, 65500, 65535, i == 11));

    // Random blocks: one register setting and one idling pattern each.
    for (int b = 0; b < 8; b++) begin
      drain();
      case (b)
        0: apply_setting(RST_LANE_INDEX, RST_FOLLOW_GAP, RST_TOP_SPEED, RST_SPEED_STEP,
                         RST_SPEED_MARGIN);
        1: apply_setting(3, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
        2: apply_setting(0, 0, 0, 0, 0);
        default: apply_setting($urandom_range(3), $urandom_range(20000, 512),
                               $urandom_range(60000, 40000), $urandom_range(4095),
                               $urandom_range(4095));
      endcase
      case (b % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 83;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 83;
        end
        default: begin
          tx_idle_pct = 16;
          rx_stall_pct = 16;
        end
      endcase
      // receiver blocked for a long stretch while beats keep coming
      if (b == 4) rx_hold = 400;
      repeat (BLOCK_BEATS) send_item(random_track());
    end

    drain();
    // keep the clock running to catch any stray result beat
    repeat (25) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
